FILE: hdl/tts_pkg.sv
// Package for the tick-to-seconds accumulator.
// Holds the command and status structs shared by the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package tts_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned FreqW   = 31;
  localparam int unsigned SecW    = 32;
  // dividend is tick difference plus held leftover, so one bit wider than a sample
  localparam int unsigned DvdW    = SampleW + 1;

  typedef struct packed {
    logic load_div;      // latch sample, form dividend, clear partial remainder
    logic div_step;      // one restoring-division iteration
    logic commit;        // fold quotient into seconds, remainder into leftover
    logic record_first;  // first sample after reset: record only
    logic out_load;      // capture result into the output register
    logic out_nr;        // result carries not_ready
  } tts_cmd_t;

  typedef struct packed {
    logic freq_zero;
    logic started;
  } tts_sts_t;

endpackage

FILE: hdl/tts_dpath.sv
// Datapath of the tick-to-seconds accumulator: frequency register, held state,
// shared bit-serial restoring divider and output register. Depends on tts_pkg.
`timescale 1ns / 1ps

module tts_dpath import tts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [FreqW-1:0]   cfg_data_i,
  input  logic [SampleW-1:0] sample_i,
  input  tts_cmd_t           cmd_i,
  output tts_sts_t           sts_o,
  output logic [SecW-1:0]    out_sec_o,
  output logic [FreqW-1:0]   out_left_o,
  output logic               out_nr_o
);

  logic [FreqW-1:0]   freq_q;
  logic [SampleW-1:0] prev_q;
  logic [SecW-1:0]    sec_q;
  logic [FreqW-1:0]   rem_q;
  logic               started_q;

  logic [DvdW-1:0]    dvd_q, dvd_d;   // dividend in, quotient out
  logic [SampleW-1:0] prem_q, prem_d; // partial remainder, always below freq

  logic [SampleW-1:0] diff;
  logic [SampleW-1:0] trial;
  logic               qbit;

  logic [SecW-1:0]    out_sec_q;
  logic [FreqW-1:0]   out_left_q;
  logic               out_nr_q;

  assign diff  = sample_i - prev_q;
  assign trial = {prem_q[SampleW-2:0], dvd_q[DvdW-1]};
  assign qbit  = (trial >= {1'b0, freq_q});

  always_comb begin
    dvd_d  = dvd_q;
    prem_d = prem_q;
    if (cmd_i.load_div) begin
      dvd_d  = {1'b0, diff} + {2'b00, rem_q};
      prem_d = '0;
    end else if (cmd_i.div_step) begin
      dvd_d  = {dvd_q[DvdW-2:0], qbit};
      prem_d = qbit ? (trial - {1'b0, freq_q}) : trial;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q    <= '0;
      prev_q    <= '0;
      sec_q     <= '0;
      rem_q     <= '0;
      started_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        freq_q <= cfg_data_i;
      end
      if (cmd_i.load_div || cmd_i.record_first) begin
        prev_q <= sample_i;
      end
      if (cmd_i.record_first) begin
        started_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        // quotient wraps into the seconds modulo 2^32
        sec_q <= sec_q + dvd_q[SecW-1:0];
        rem_q <= prem_q[FreqW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    prem_q <= prem_d;
    if (cmd_i.out_load) begin
      out_sec_q  <= cmd_i.out_nr ? '0 : sec_q;
      out_left_q <= cmd_i.out_nr ? '0 : rem_q;
      out_nr_q   <= cmd_i.out_nr;
    end
  end

  assign sts_o.freq_zero = (freq_q == '0);
  assign sts_o.started   = started_q;
  assign out_sec_o  = out_sec_q;
  assign out_left_o = out_left_q;
  assign out_nr_o   = out_nr_q;

endmodule

FILE: hdl/tts_ctrl.sv
// Controller of the tick-to-seconds accumulator: sequences accept, division,
// commit and output hand-over. Depends on tts_pkg.
`timescale 1ns / 1ps

module tts_ctrl import tts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  tts_sts_t sts_i,
  output tts_cmd_t cmd_o
);

  localparam int unsigned DivSteps = DvdW;
  localparam int unsigned CntW     = $clog2(DivSteps);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StDiv    = 2'd1;
  localparam logic [1:0] StCommit = 2'd2;
  localparam logic [1:0] StFin    = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            nr_q, nr_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;
  logic            accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    nr_d    = nr_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (sts_i.freq_zero) begin
            nr_d    = 1'b1;
            state_d = StFin;
          end else if (!sts_i.started) begin
            cmd_o.record_first = 1'b1;
            nr_d    = 1'b0;
            state_d = StFin;
          end else begin
            cmd_o.load_div = 1'b1;
            nr_d    = 1'b0;
            cnt_d   = '0;
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = StCommit;
        end
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        state_d = StFin;
      end
      StFin: begin
        // hold the finished result until the output register frees up
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    cmd_o.out_nr = nr_q;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      nr_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      nr_q        <= nr_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/tick_to_seconds_accumulator.sv
// Channel  Dir  Handshake                   Payload
// cfg      in   cfg_valid_i / cfg_ready_o   cfg_data_i: tick_frequency[30:0]
// s_axis   in   s_axis_tvalid / tready      tdata: tick_sample[31:0]
// m_axis   out  m_axis_tvalid / tready      tdata: seconds, leftover; tuser: not_ready
//
// A sample that starts a division goes through accept, 33 iterations of the bit-serial
// divider, commit and hand-over to the output register; the hand-over waits while the
// output is stalled. A zero-frequency or first sample goes from accept to hand-over.
// The next request is taken as soon as the result sits in the output register.
// A stalled output holds the finished result in the controller until the register frees.
// Reset clears the frequency (not ready), the held state and the first-sample flag.
// Depends on tts_pkg, tts_ctrl and tts_dpath.
`timescale 1ns / 1ps

module tick_to_seconds_accumulator import tts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [30:0] cfg_data_i,     // tick_frequency
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] tick_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] elapsed_seconds, [62:32] leftover_ticks, pad
  output logic        m_axis_tuser    // [0] not_ready
);

  tts_cmd_t         cmd;
  tts_sts_t         sts;
  logic [SecW-1:0]  out_sec;
  logic [FreqW-1:0] out_left;
  logic             out_nr;

  assign cfg_ready_o = 1'b1;

  tts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tts_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .sample_i   (s_axis_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_sec_o  (out_sec),
    .out_left_o (out_left),
    .out_nr_o   (out_nr)
  );

  assign m_axis_tdata = {1'b0, out_left, out_sec};
  assign m_axis_tuser = out_nr;

endmodule
